// ===== rtl/core/glos_pkg.sv =====
// Package for the grid line-of-sight core: payload structs, state codes and
// the command and status groups between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package glos_pkg;

  // Default map size and fixed field widths.
  localparam int unsigned MapWidthDef  = 64;
  localparam int unsigned MapHeightDef = 64;
  localparam int unsigned CoordW       = 6;
  localparam int unsigned RangeW       = 4;
  localparam logic [RangeW-1:0] ViewRangeRst = 4'd6;

  // Kind of an input item.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // One input item.
  typedef struct packed {
    action_e           action;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] to_x;
    logic [CoordW-1:0] to_y;
    logic              cell_blocked;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic visible;
    logic beyond_range;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic take_item;
    logic setup;
    logic walk;
    logic load_result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic need_walk;
    logic walk_last;
  } dp_status_t;

endpackage

// ===== rtl/core/glos_ctrl.sv =====
// Controller state machine for the grid line-of-sight core.
// Depends on glos_pkg for the state, command and status types.
`timescale 1ns / 1ps

module glos_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  glos_pkg::action_e     in_action_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  glos_pkg::dp_status_t  status_i,
  output glos_pkg::ctrl_cmd_t   cmd_o
);
  import glos_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_action_i == ACT_QUERY) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = status_i.need_walk ? ST_WALK : ST_RESULT;
      end
      ST_WALK: begin
        if (status_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take_item = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.load_result = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid flag: set on load, cleared by a transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is never loaded over one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled result");

  // A loaded result is offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> out_valid_o)
    else $error("loaded result not offered");

  // An accepted query always starts with setup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_item && in_action_i == ACT_QUERY) |=> state_q == ST_SETUP)
    else $error("accepted query did not enter setup");

  // No input is taken while the map is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && !cmd_o.take_item)
    else $error("input taken during clearing pass");

endmodule

// ===== rtl/core/glos_datapath.sv =====
// Datapath of the grid line-of-sight core: obstruction map memory, view
// range register, setup of the walk, incremental minor-axis stepping and
// the result register. Depends on glos_pkg.
`timescale 1ns / 1ps

module glos_datapath #(
  parameter int unsigned MAP_WIDTH  = glos_pkg::MapWidthDef,
  parameter int unsigned MAP_HEIGHT = glos_pkg::MapHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  glos_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [glos_pkg::RangeW-1:0]   cfg_wdata_i,
  input  glos_pkg::ctrl_cmd_t           cmd_i,
  output glos_pkg::dp_status_t          status_o,
  output glos_pkg::out_item_t           out_item_o
);
  import glos_pkg::*;

  localparam int unsigned Depth = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  // Map storage, one bit per cell.
  logic mem [Depth];

  logic [AddrW-1:0]  clr_q;
  logic [RangeW-1:0] view_range_q;
  in_item_t          item_q;
  out_item_t         out_q;

  // Walk state.
  logic [RangeW-1:0] steps_q, k_q;
  logic              major_y_q, neg_q, far_q, blocked_q;
  logic signed [4:0] dm_q;
  logic signed [6:0] r_q;
  logic [CoordW-1:0] maj_q, min_q;
  logic              rd_pend_q, rd_data_q;

  // Map address from a cell, valid only when the cell lies in the map.
  function automatic logic [AddrW-1:0] cell_addr(logic [CoordW-1:0] x,
                                                 logic [CoordW-1:0] y);
    return AddrW'(AddrW'(y) * AddrW'(MAP_WIDTH) + AddrW'(x));
  endfunction

  function automatic logic cell_in_map(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    return (32'(x) < MAP_WIDTH) && (32'(y) < MAP_HEIGHT);
  endfunction

  // Setup: deltas, range test and major axis choice.
  logic signed [6:0] dx, dy;
  logic [CoordW-1:0] adx, ady;
  logic              far, major_y;
  logic [RangeW-1:0] steps;

  always_comb begin
    dx      = $signed({1'b0, item_q.to_x}) - $signed({1'b0, item_q.from_x});
    dy      = $signed({1'b0, item_q.to_y}) - $signed({1'b0, item_q.from_y});
    adx     = dx[6] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady     = dy[6] ? CoordW'(-dy) : dy[CoordW-1:0];
    far     = (adx > CoordW'(view_range_q)) || (ady > CoordW'(view_range_q));
    major_y = adx < ady;
    steps   = major_y ? ady[RangeW-1:0] : adx[RangeW-1:0];
  end

  // One step of the walk: advance the major axis, carry the rounding
  // remainder and move the minor axis by at most one cell.
  logic signed [7:0] r_sum, two_s;
  logic signed [6:0] r_n;
  logic [CoordW-1:0] maj_n, min_n, x_n, y_n;

  always_comb begin
    r_sum = 8'(r_q) + 8'($signed({dm_q, 1'b0}));
    two_s = $signed({3'b000, steps_q, 1'b0});
    maj_n = neg_q ? maj_q - 1'b1 : maj_q + 1'b1;
    if (r_sum >= two_s) begin
      r_n   = 7'(r_sum - two_s);
      min_n = min_q + 1'b1;
    end else if (r_sum < 0) begin
      r_n   = 7'(r_sum + two_s);
      min_n = min_q - 1'b1;
    end else begin
      r_n   = 7'(r_sum);
      min_n = min_q;
    end
    x_n = major_y_q ? min_n : maj_n;
    y_n = major_y_q ? maj_n : min_n;
  end

  assign status_o.clr_last  = clr_q == AddrW'(Depth - 1);
  assign status_o.need_walk = !far && (steps >= RangeW'(2));
  assign status_o.walk_last = k_q == steps_q - 1'b1;

  // Memory write port: clearing pass or a map write item.
  logic             mem_we, mem_wdata;
  logic [AddrW-1:0] mem_waddr;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = cmd_i.take_item && in_item_i.action == ACT_WRITE &&
                  cell_in_map(in_item_i.from_x, in_item_i.from_y);
      mem_waddr = cell_addr(in_item_i.from_x, in_item_i.from_y);
      mem_wdata = in_item_i.cell_blocked;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // Registered map read for the next cell on the walk.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[cell_addr(x_n, y_n)];
  end

  // Control state: clear counter, range register, step counter, read and block flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      view_range_q <= ViewRangeRst;
      rd_pend_q    <= 1'b0;
      blocked_q    <= 1'b0;
      k_q          <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) view_range_q <= cfg_wdata_i;
      rd_pend_q <= cmd_i.walk && cell_in_map(x_n, y_n);
      if (cmd_i.setup) begin
        blocked_q <= 1'b0;
        k_q       <= RangeW'(1);
      end else begin
        if (rd_pend_q && rd_data_q) blocked_q <= 1'b1;
        if (cmd_i.walk) k_q <= k_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) item_q <= in_item_i;
    if (cmd_i.setup) begin
      far_q     <= far;
      steps_q   <= steps;
      major_y_q <= major_y;
      neg_q     <= major_y ? dy[6] : dx[6];
      dm_q      <= major_y ? dx[4:0] : dy[4:0];
      r_q       <= 7'(steps);
      maj_q     <= major_y ? item_q.from_y : item_q.from_x;
      min_q     <= major_y ? item_q.from_x : item_q.from_y;
    end else if (cmd_i.walk) begin
      maj_q <= maj_n;
      min_q <= min_n;
      r_q   <= r_n;
    end
    if (cmd_i.load_result) begin
      out_q.visible      <= !far_q && !blocked_q;
      out_q.beyond_range <= far_q;
    end
  end

  assign out_item_o = out_q;

  // The walk never issues more reads than there are cells between the ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (k_q < steps_q))
    else $error("walk ran past the target");

  // A pending read always follows a walk step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(cmd_i.walk))
    else $error("read pending without a walk step");

  // The rounding remainder stays within one period of the step size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |=> (r_q >= 0) && (8'(r_q) < $signed({3'b000, steps_q, 1'b0})))
    else $error("rounding remainder out of range");

endmodule

// ===== rtl/core/grid_line_of_sight_core.sv =====
// Top level of the grid line-of-sight core: controller plus datapath.
// Depends on glos_pkg, glos_ctrl and glos_datapath.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i, in_stall_o, in_item_i) takes map writes and
// line-of-sight queries one at a time. A write gives no result. A query
// gives one result item on the output channel (out_valid_o, out_stall_i,
// out_item_o).
// A query with S = max(|dx|, |dy|) cells along its major axis is taken, set
// up, walks the S-1 cells between the ends at one map read per cycle, drains
// the last read, then loads the result once the output register is free. A
// target that is out of range, adjacent or the viewer's own cell goes from
// setup straight to the result. The walk reads the obstruction map through
// its single read port. A finished result waits in the output register while
// the receiver stalls; the next item is taken meanwhile and its result waits
// until that register drains. view_range is to be written through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this. After
// reset the map is cleared, one cell a cycle over all MAP_WIDTH * MAP_HEIGHT
// cells (4096 by default), with the input stalled.
module grid_line_of_sight_core #(
  parameter int unsigned MAP_WIDTH  = glos_pkg::MapWidthDef,
  parameter int unsigned MAP_HEIGHT = glos_pkg::MapHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  glos_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output glos_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [glos_pkg::RangeW-1:0]  cfg_wdata_i
);
  import glos_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing of clearing, setup, walk and result.
  glos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Map, range register and walk arithmetic.
  glos_datapath #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule
